@@ src/aging_pr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aging page replacement package
// Field widths, reset values and the control types shared by the core,
// its interfaces and its remainder unit.
// ----------------------------------------------------------------------------
package aging_pr_pkg;

    // Widths of the request and result fields.
    localparam int PAGE_W  = 11;
    localparam int FRAME_W = 9;
    localparam int TIME_W  = 32;
    localparam int INTV_W  = 16;
    localparam int AGE_W   = 8;

    // Reset values of the aging byte and the aging interval.
    localparam logic [AGE_W-1:0]  AGE_FULL   = 8'hFF;
    localparam logic [INTV_W-1:0] INTV_RESET = 16'd100;

    // Start request for the remainder unit.
    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] dividend;
        logic [INTV_W-1:0] divisor;
    } t_rem_req;

    // Status returned by the remainder unit.
    typedef struct packed {
        logic busy;
        logic zero;
    } t_rem_sts;

endpackage

@@ src/aging_pr_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aging page replacement channels
// Request, result and configuration channels with a valid/ready handshake.
// ----------------------------------------------------------------------------

// Page request channel.
interface aging_pr_req_if;
    logic                             valid;
    logic                             ready;
    logic                             mode;
    logic [aging_pr_pkg::PAGE_W-1:0]  vpage;
    logic [aging_pr_pkg::TIME_W-1:0]  stamp;

    modport source (output valid, output mode, output vpage, output stamp,
                    input ready);
    modport sink (input valid, input mode, input vpage, input stamp,
                  output ready);
endinterface

// Result channel.
interface aging_pr_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             fault;
    logic [aging_pr_pkg::PAGE_W-1:0]  echo_page;
    logic [aging_pr_pkg::FRAME_W-1:0] victim_frame;
    logic [aging_pr_pkg::PAGE_W-1:0]  evicted_page;

    modport source (output valid, output fault, output echo_page,
                    output victim_frame, output evicted_page, input ready);
    modport sink (input valid, input fault, input echo_page,
                  input victim_frame, input evicted_page, output ready);
endinterface

// Configuration write channel for the aging interval.
interface aging_pr_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [aging_pr_pkg::INTV_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/aging_pr_mod.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aging page replacement remainder unit
// Restoring remainder of the time stamp by the aging interval, one
// dividend bit per cycle.
// ----------------------------------------------------------------------------
module aging_pr_mod (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  aging_pr_pkg::t_rem_req i_req,
    output aging_pr_pkg::t_rem_sts o_sts
);

    localparam int TW = aging_pr_pkg::TIME_W;
    localparam int IW = aging_pr_pkg::INTV_W;
    localparam int CW = $clog2(TW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [TW-1:0] r_dvd;
    logic [IW-1:0] r_div;
    logic [IW-1:0] r_rem;
    logic [IW:0]   w_trial;
    logic [IW-1:0] n_rem;

    // One restoring step: bring in the next dividend bit and subtract if it fits.
    always_comb begin
        w_trial = {r_rem, r_dvd[TW-1]};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = IW'(w_trial - {1'b0, r_div});
        end else begin
            n_rem = IW'(w_trial);
        end
    end

    // Control of the step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(TW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath of the remainder.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[TW-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.zero = (r_rem == '0);

endmodule

@@ src/aging_page_replacement_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aging page replacement core
// Page lookup with victim choice by aging byte (LRU) or by bit count (LFU).
// ----------------------------------------------------------------------------
// A request word carries mode, vpage and stamp and returns exactly
// one result word with fault, the echoed page, the victim frame and the page
// evicted from it. The aging interval is written over the configuration
// channel, which is always ready; write it only while the core is idle.
// One request is served at a time and the request channel is not ready meanwhile.
// A hit waits for the bit-serial remainder of stamp by the interval (one bit
// per cycle) before it gives its result word. A fault scans all NUM_FRAMES
// aging bytes through the frame memory read port, and the remainder runs
// hidden behind the scan. An aging sweep adds another pass through the same port.
// After reset the core runs a clearing pass that loads the map memories
// before the first request is taken.
// A result waits in the output register until the receiver takes it; the
// next request can be accepted at the edge after that.
// ----------------------------------------------------------------------------
module aging_page_replacement_core #(
    parameter int NUM_PAGES  = 2048,
    parameter int NUM_FRAMES = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    aging_pr_req_if.sink          i_req,
    aging_pr_rsp_if.source        o_rsp,
    aging_pr_cfg_if.sink          i_cfg
);

    localparam int PGW   = aging_pr_pkg::PAGE_W;
    localparam int FRW   = aging_pr_pkg::FRAME_W;
    localparam int AW    = aging_pr_pkg::AGE_W;
    localparam int PW    = $clog2(NUM_PAGES);
    localparam int FW    = $clog2(NUM_FRAMES);
    localparam int OW    = (FW > PGW) ? FW : PGW;
    localparam int CLR_N = (NUM_PAGES > NUM_FRAMES) ? NUM_PAGES : NUM_FRAMES;
    localparam int CW    = $clog2(CLR_N);

    typedef enum logic [11:0] {
        S_CLEAR = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_RDPG  = 12'b0000_0000_0100,
        S_CHK   = 12'b0000_0000_1000,
        S_SCAN  = 12'b0000_0001_0000,
        S_OWN   = 12'b0000_0010_0000,
        S_OWN2  = 12'b0000_0100_0000,
        S_INV   = 12'b0000_1000_0000,
        S_REF   = 12'b0001_0000_0000,
        S_WAIT  = 12'b0010_0000_0000,
        S_SWEEP = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } t_state;

    // Number of set bits in an aging byte.
    function automatic logic [3:0] ones_in(input logic [AW-1:0] v);
        logic [3:0] n;
        n = '0;
        for (int k = 0; k < AW; k++) begin
            n = n + 4'(v[k]);
        end
        return n;
    endfunction

    t_state r_state;

    // Memories: page map rows are {valid, frame}.
    logic [FW:0]    r_page_mem  [NUM_PAGES];
    logic [OW-1:0]  r_owner_mem [NUM_FRAMES];
    logic [AW-1:0]  r_age_mem   [NUM_FRAMES];
    logic           r_ref_mem   [NUM_FRAMES];
    logic [FW:0]    r_page_q;
    logic [OW-1:0]  r_owner_q;
    logic [AW-1:0]  r_age_q;
    logic           r_ref_q;

    // Request and result registers.
    logic [aging_pr_pkg::INTV_W-1:0] r_interval;
    logic [CW-1:0]  r_clr;
    logic           r_mode;
    logic [PGW-1:0] r_page;
    logic           r_time_nz;
    logic [FW:0]    r_idx;
    logic [FW-1:0]  r_best;
    logic [AW-1:0]  r_best_key;
    logic [FW-1:0]  r_frame;
    logic [OW-1:0]  r_old;
    logic           r_fault;
    logic [FRW-1:0] r_frame_out;
    logic [PGW-1:0] r_old_out;

    // Write ports of the memories.
    logic           w_pm_we;
    logic [PW-1:0]  w_pm_addr;
    logic [FW:0]    w_pm_wd;
    logic           w_om_we;
    logic [FW-1:0]  w_om_addr;
    logic [OW-1:0]  w_om_wd;
    logic           w_am_we;
    logic [FW-1:0]  w_am_addr;
    logic [AW-1:0]  w_am_wd;
    logic           w_rm_we;
    logic [FW-1:0]  w_rm_addr;
    logic           w_rm_wd;
    logic [FW-1:0]  w_prev;
    logic [AW-1:0]  w_key;
    logic           w_accept;
    logic           w_in_range;

    aging_pr_pkg::t_rem_req w_rem_req;
    aging_pr_pkg::t_rem_sts w_rem_sts;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_in_range = (32'(i_req.vpage) < NUM_PAGES);
    assign w_prev     = FW'(r_idx - 1'b1);
    assign w_key      = r_mode ? AW'(ones_in(r_age_q)) : r_age_q;

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // Remainder of the time stamp by the interval runs alongside the lookup.
    assign w_rem_req.start    = w_accept;
    assign w_rem_req.dividend = i_req.stamp;
    assign w_rem_req.divisor  = r_interval;

    aging_pr_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_rem_req),
        .o_sts   (w_rem_sts)
    );

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= aging_pr_pkg::INTV_RESET;
        end else if (i_cfg.valid) begin
            r_interval <= i_cfg.data;
        end
    end

    // Page map write port: reset load, fault update and eviction.
    always_comb begin
        w_pm_we   = 1'b0;
        w_pm_addr = PW'(r_page);
        w_pm_wd   = '0;
        priority if (r_state == S_CLEAR) begin
            w_pm_we   = (32'(r_clr) < NUM_PAGES);
            w_pm_addr = PW'(r_clr);
            w_pm_wd   = (32'(r_clr) < NUM_FRAMES) ? {1'b1, FW'(r_clr)} : '0;
        end else if (r_state == S_OWN2) begin
            w_pm_we = 1'b1;
            w_pm_wd = {1'b1, r_best};
        end else if (r_state == S_INV) begin
            w_pm_we   = 1'b1;
            w_pm_addr = PW'(r_old);
        end else begin
            w_pm_we = 1'b0;
        end
    end

    // Frame owner write port.
    always_comb begin
        w_om_we   = 1'b0;
        w_om_addr = r_best;
        w_om_wd   = OW'(r_page);
        priority if (r_state == S_CLEAR) begin
            w_om_we   = (32'(r_clr) < NUM_FRAMES);
            w_om_addr = FW'(r_clr);
            w_om_wd   = OW'(r_clr);
        end else if (r_state == S_OWN2) begin
            w_om_we = 1'b1;
        end else begin
            w_om_we = 1'b0;
        end
    end

    // Aging byte and referenced bit write ports.
    always_comb begin
        w_am_we   = 1'b0;
        w_am_addr = w_prev;
        w_am_wd   = {r_ref_q, r_age_q[AW-1:1]};
        w_rm_we   = 1'b0;
        w_rm_addr = w_prev;
        w_rm_wd   = 1'b0;
        priority if (r_state == S_CLEAR) begin
            w_am_we   = (32'(r_clr) < NUM_FRAMES);
            w_am_addr = FW'(r_clr);
            w_am_wd   = aging_pr_pkg::AGE_FULL;
            w_rm_we   = (32'(r_clr) < NUM_FRAMES);
            w_rm_addr = FW'(r_clr);
            w_rm_wd   = 1'b1;
        end else if (r_state == S_REF) begin
            w_rm_we   = 1'b1;
            w_rm_addr = r_frame;
            w_rm_wd   = 1'b1;
        end else if (r_state == S_SWEEP) begin
            w_am_we = (r_idx != '0);
            w_rm_we = (r_idx != '0);
        end else begin
            w_am_we = 1'b0;
        end
    end

    // Memories with registered reads.
    always_ff @(posedge i_clk) begin
        if (w_pm_we) begin
            r_page_mem[w_pm_addr] <= w_pm_wd;
        end
        r_page_q <= r_page_mem[PW'(r_page)];
    end

    always_ff @(posedge i_clk) begin
        if (w_om_we) begin
            r_owner_mem[w_om_addr] <= w_om_wd;
        end
        r_owner_q <= r_owner_mem[r_best];
    end

    always_ff @(posedge i_clk) begin
        if (w_am_we) begin
            r_age_mem[w_am_addr] <= w_am_wd;
        end
        r_age_q <= r_age_mem[r_idx[FW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_rm_we) begin
            r_ref_mem[w_rm_addr] <= w_rm_wd;
        end
        r_ref_q <= r_ref_mem[r_idx[FW-1:0]];
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (32'(r_clr) == CLR_N - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_mode      <= i_req.mode;
                        r_page      <= i_req.vpage;
                        r_time_nz   <= (i_req.stamp != '0);
                        r_fault     <= 1'b0;
                        r_frame_out <= '0;
                        r_old_out   <= '0;
                        r_state     <= w_in_range ? S_RDPG : S_OUT;
                    end
                end
                S_RDPG: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_idx <= '0;
                    if (r_page_q[FW]) begin
                        r_frame <= r_page_q[FW-1:0];
                        r_state <= S_REF;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // Compare the frame read in the previous cycle.
                    if (r_idx != '0) begin
                        if (r_idx == (FW+1)'(1) || w_key < r_best_key) begin
                            r_best     <= w_prev;
                            r_best_key <= w_key;
                        end
                    end
                    if (r_idx == (FW+1)'(NUM_FRAMES)) begin
                        r_state <= S_OWN;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_OWN: begin
                    r_state <= S_OWN2;
                end
                S_OWN2: begin
                    r_old       <= r_owner_q;
                    r_fault     <= 1'b1;
                    r_frame     <= r_best;
                    r_frame_out <= FRW'(r_best);
                    r_old_out   <= PGW'(r_owner_q);
                    r_state     <= (32'(r_owner_q) < NUM_PAGES) ? S_INV : S_REF;
                end
                S_INV: begin
                    r_state <= S_REF;
                end
                S_REF: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    r_idx <= '0;
                    if (!w_rem_sts.busy) begin
                        if (r_time_nz && r_interval != '0 && w_rem_sts.zero) begin
                            r_state <= S_SWEEP;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_SWEEP: begin
                    if (r_idx == (FW+1)'(NUM_FRAMES)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_OUT: begin
                    if (o_rsp.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                    r_clr   <= '0;
                end
            endcase
        end
    end

    // Result word.
    assign o_rsp.valid        = (r_state == S_OUT);
    assign o_rsp.fault        = r_fault;
    assign o_rsp.echo_page    = r_page;
    assign o_rsp.victim_frame = r_frame_out;
    assign o_rsp.evicted_page = r_old_out;

endmodule
